[sv/ovl_pkg.sv]
// Package: types and constants shared by the ordered value list modules.
package ovl_pkg;
	localparam int Depth = 16;
	localparam int DataWidth = 32;
	localparam int IdxW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	typedef enum logic [2:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_DELETE     = 3'd2,
		REQ_SIZE       = 3'd3,
		REQ_DUMP       = 3'd4,
		REQ_CLEAR      = 3'd5,
		REQ_FIND       = 3'd6,
		REQ_CHANGE     = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]                   req_type;
		logic signed [DataWidth-1:0]  key;
		logic signed [DataWidth-1:0]  new_value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]                   status;
		logic [CntW-1:0]              count;
		logic signed [DataWidth-1:0]  item_value;
		logic                         item_valid;
		logic                         last;
	} out_word_t;
endpackage

[sv/ordered_value_list_top.sv]
// Top level of the ordered value list: request queue followed by the list engine.
// Holds up to 16 signed 32-bit words in order. Each request leaves the two-word
// input queue for the engine, which registers its result; a dump walks the
// stored words out through the single output register, holds on an output stall
// and takes no new request until done. Each request yields one word, except a
// dump of a non-empty list: one word per stored value, last on the final one.
module ordered_value_list_top import ovl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);
	logic     q_valid, q_stall;
	in_word_t q_data;

	ovl_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
	);

	ovl_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.req_valid(q_valid), .req_stall(q_stall), .req(q_data),
		.res_valid(out_valid), .res_stall(out_stall), .res(out_data)
	);
endmodule

[sv/ovl_queue.sv]
// Two-entry queue that decouples request intake from the list engine.
module ovl_queue import ovl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output in_word_t out_data
);
	in_word_t  mem_q [2];
	logic      wr_q, rd_q;
	logic [1:0] cnt_q;
	logic      push, pop;

	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_q];
	assign push = in_valid && !in_stall;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

[sv/ovl_engine.sv]
// List engine: row of cells with parallel match, shifts on front insert and delete, dump walk.
module ovl_engine import ovl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_word_t  req,
	output logic      res_valid,
	input  logic      res_stall,
	output out_word_t res
);
	logic [DataWidth-1:0] cell_q [Depth];
	logic [CntW-1:0]      cnt_q;
	logic                 dump_q;
	logic [IdxW-1:0]      dptr_q;
	logic                 ovalid_q;
	out_word_t            res_q;

	logic                 out_free, take;
	logic [Depth-1:0]     hit, first;
	logic                 any_hit;
	logic                 full;

	assign out_free  = !ovalid_q || !res_stall;
	assign req_stall = dump_q || !out_free;
	assign take      = req_valid && !req_stall;
	assign full      = (cnt_q == CntW'(Depth));
	assign res_valid = ovalid_q;
	assign res       = res_q;

	always_comb begin
		for (int i = 0; i < Depth; i++)
			hit[i] = (CntW'(i) < cnt_q) && (cell_q[i] == req.key);
		first = hit & (~hit + 1'b1);
		any_hit = |hit;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			unique case (req_t'(req.req_type))
				REQ_PUSH_FRONT: if (!full) begin
					for (int i = Depth - 1; i > 0; i--) cell_q[i] <= cell_q[i-1];
					cell_q[0] <= req.key;
				end
				REQ_PUSH_BACK: if (!full) cell_q[cnt_q[IdxW-1:0]] <= req.key;
				REQ_DELETE: begin
					// shift down everything at or past the first match
					for (int i = 0; i < Depth - 1; i++)
						if (|(first & ((Depth'(1) << (i + 1)) - 1'b1)))
							cell_q[i] <= cell_q[i+1];
				end
				REQ_CHANGE: begin
					for (int i = 0; i < Depth; i++)
						if (first[i]) cell_q[i] <= req.new_value;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			dump_q <= 1'b0;
			dptr_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && !res_stall && !dump_q) ovalid_q <= 1'b0;
			if (dump_q && out_free) begin
				// advance the walk one word per free output slot
				ovalid_q <= 1'b1;
				res_q.status <= ST_DONE;
				res_q.count <= cnt_q;
				res_q.item_value <= cell_q[dptr_q];
				res_q.item_valid <= 1'b1;
				res_q.last <= ({1'b0, dptr_q} + 1'b1 == {1'b0, cnt_q});
				if ({1'b0, dptr_q} + 1'b1 == {1'b0, cnt_q}) dump_q <= 1'b0;
				dptr_q <= dptr_q + 1'b1;
			end else if (take) begin
				logic [1:0]      st;
				logic [CntW-1:0] nc;
				st = ST_DONE;
				nc = cnt_q;
				unique case (req_t'(req.req_type))
					REQ_PUSH_FRONT, REQ_PUSH_BACK:
						if (full) st = ST_FULL; else nc = cnt_q + 1'b1;
					REQ_DELETE:
						if (!any_hit) st = ST_NOT_FOUND; else nc = cnt_q - 1'b1;
					REQ_SIZE: if (cnt_q == '0) st = ST_EMPTY;
					REQ_DUMP: if (cnt_q == '0) st = ST_EMPTY;
					REQ_CLEAR: nc = '0;
					REQ_FIND, REQ_CHANGE: if (!any_hit) st = ST_NOT_FOUND;
					default: ;
				endcase
				cnt_q <= nc;
				if (req_t'(req.req_type) == REQ_DUMP && cnt_q != '0) begin
					dump_q <= 1'b1;
					dptr_q <= '0;
					ovalid_q <= 1'b0;
				end else begin
					ovalid_q <= 1'b1;
					res_q.status <= st;
					res_q.count <= nc;
					res_q.item_value <= '0;
					res_q.item_valid <= 1'b0;
					res_q.last <= 1'b1;
				end
			end
		end
	end
endmodule
